@@ design/assert_macros.svh @@
// Assertion macros shared by the timer queue RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/dotq_pkg.sv @@
// Shared constants, codes and types of the deadline ordered timer queue.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package dotq_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int TICK_W      = 64;
  localparam int PERIOD_W    = 32;
  localparam int ID_W        = 8;
  localparam int KIND_W      = 2;
  localparam int REP_W       = $clog2(MAX_RESULTS + 1);

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  localparam logic [KIND_W-1:0] KIND_FIRED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ZERO  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FULL  = 2'd3;

  // One timer as held in the table.
  typedef struct packed {
    logic [TICK_W-1:0]   deadline;
    logic [PERIOD_W-1:0] period;
    logic [ID_W-1:0]     ident;
    logic                once;
  } entry_t;

  // Flags produced by the shared compare unit.
  typedef struct packed {
    logic due;
    logic later;
  } cmp_res_t;

endpackage

@@ design/dotq_table.sv @@
// Timer table storage: one write port and one read port with registered data.
// Depends on dotq_pkg for the entry type.
`timescale 1ns / 1ps

module dotq_table #(
  parameter int DEPTH = dotq_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  dotq_pkg::entry_t     wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output dotq_pkg::entry_t     rdata
);

  dotq_pkg::entry_t mem [DEPTH];

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/dotq_cmp.sv @@
// Shared compare unit: remaining-ticks test for the ordered insert and the
// expiry test for the scan. Depends on dotq_pkg for widths and the flag type.
`timescale 1ns / 1ps

module dotq_cmp (
  input  logic [dotq_pkg::TICK_W-1:0]   deadline,
  input  logic [dotq_pkg::TICK_W-1:0]   tick_count,
  input  logic [dotq_pkg::PERIOD_W-1:0] period,
  output dotq_pkg::cmp_res_t            res
);

  logic [dotq_pkg::TICK_W-1:0] remain;

  // Remaining ticks wrap modulo the counter width, so order survives the wrap.
  assign remain    = deadline - tick_count;
  assign res.later = remain > {{(dotq_pkg::TICK_W - dotq_pkg::PERIOD_W){1'b0}}, period};
  assign res.due   = deadline == tick_count;

endmodule

@@ design/deadline_ordered_timer_queue.sv @@
// Top level of the deadline ordered timer queue: sequencer, tick counter,
// table pointers and result register. Depends on dotq_pkg, dotq_table, dotq_cmp.
//
//   channel   handshake                  words carried
//   item      item_valid / item_ready    cmd, timer_id, interval, one_shot
//   result    result_valid / result_ready kind, fired_id, last
//
// A set word moves each timer that sits later than the new one up one slot,
// one per cycle through the table's read port and write port, then writes the
// new one. A tick word pops each expired timer in turn and re-inserts each
// periodic timer that is re-armed the same way.
// Reset is synchronous and empties the table; no clearing pass is needed.
// A stalled result register holds the sequencer only when it has a new word
// to hand over; item_ready returns as soon as the last word is registered.
`timescale 1ns / 1ps

module deadline_ordered_timer_queue #(
  parameter int DEPTH = dotq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic                              cmd,
  input  logic [dotq_pkg::ID_W-1:0]         timer_id,
  input  logic [dotq_pkg::PERIOD_W-1:0]     interval,
  input  logic                              one_shot,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic [dotq_pkg::KIND_W-1:0]       kind,
  output logic [dotq_pkg::ID_W-1:0]         fired_id,
  output logic                              last
);

  `include "assert_macros.svh"

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW:0]   DEPTH_I = (IW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [dotq_pkg::REP_W-1:0] REP_MAX = dotq_pkg::REP_W'(dotq_pkg::MAX_RESULTS);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_INS_START = 8'b0000_0010,
    S_INS_CMP   = 8'b0000_0100,
    S_INS_WR    = 8'b0000_1000,
    S_POP_RD    = 8'b0001_0000,
    S_POP_CMP   = 8'b0010_0000,
    S_FLUSH     = 8'b0100_0000,
    S_RESP      = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // The table is a ring: logical slot 0 sits at head, so expiring the front
  // timer only moves head instead of shifting the whole table down.
  logic [dotq_pkg::TICK_W-1:0]   tick_count;
  logic [IW-1:0]                 head;
  logic [CW-1:0]                 count;
  logic [IW-1:0]                 j;
  logic [dotq_pkg::TICK_W-1:0]   ins_deadline;
  logic [dotq_pkg::PERIOD_W-1:0] ins_period;
  logic [dotq_pkg::ID_W-1:0]     ins_ident;
  logic                          ins_once;
  logic                          ticking;
  logic [dotq_pkg::ID_W-1:0]     pend_id;
  logic                          pend_valid;
  logic [dotq_pkg::REP_W-1:0]    nrep;
  logic [dotq_pkg::KIND_W-1:0]   resp_kind;
  logic [dotq_pkg::ID_W-1:0]     resp_id;

  logic                          accept;
  logic                          out_free;
  logic                          push;
  logic [dotq_pkg::KIND_W-1:0]   push_kind;
  logic [dotq_pkg::ID_W-1:0]     push_id;
  logic                          push_last;
  logic                          rep_open;
  logic                          pop_go;
  logic [CW-1:0]                 cnt_m1;
  logic [dotq_pkg::PERIOD_W-1:0] add_period;
  logic [dotq_pkg::TICK_W-1:0]   dl_sum;

  logic                          mem_we;
  logic [IW-1:0]                 mem_waddr;
  logic [IW-1:0]                 mem_raddr;
  dotq_pkg::entry_t              mem_wdata;
  dotq_pkg::entry_t              rdata;
  dotq_pkg::cmp_res_t            cres;

  // Physical slot of a logical offset from head, folded back into the ring.
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [IW-1:0] off);
    logic [IW:0] s;
    s = {1'b0, h} + {1'b0, off};
    if (s >= DEPTH_I) begin
      s = s - DEPTH_I;
    end
    return s[IW-1:0];
  endfunction

  dotq_table #(.DEPTH(DEPTH)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  dotq_cmp u_cmp (
    .deadline   (rdata.deadline),
    .tick_count (tick_count),
    .period     (ins_period),
    .res        (cres)
  );

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;
  assign cnt_m1     = count - CW'(1);
  assign rep_open   = (nrep != REP_MAX);

  // A due timer may leave the table unless the report limit is still open and
  // an earlier report still waits for the result register.
  assign pop_go = cres.due && !(rep_open && pend_valid && !out_free);

  // One adder forms every new deadline: tick count plus the interval of a new
  // timer, or tick count plus the period of a timer being re-armed.
  assign add_period = (state == S_IDLE) ? interval : rdata.period;
  assign dl_sum     = tick_count + {{(dotq_pkg::TICK_W - dotq_pkg::PERIOD_W){1'b0}}, add_period};

  always_comb begin
    state_next = state;
    push       = 1'b0;
    push_kind  = dotq_pkg::KIND_FIRED;
    push_id    = pend_id;
    push_last  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = phys(head, j);
    mem_wdata  = rdata;
    mem_raddr  = head;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd == dotq_pkg::CMD_TICK) begin
            state_next = S_POP_RD;
          end else if (interval == '0 || count == DEPTH_C) begin
            state_next = S_RESP;
          end else begin
            state_next = S_INS_START;
          end
        end
      end
      S_INS_START: begin
        // Start the backward walk at the last filled slot.
        mem_raddr = phys(head, cnt_m1[IW-1:0]);
        if (count == '0) begin
          state_next = S_INS_WR;
        end else begin
          state_next = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        // Fetch the slot below while the current one is tested and moved up.
        mem_raddr = phys(head, (j == '0) ? j : j - IW'(1));
        if (cres.later) begin
          mem_we    = 1'b1;
          mem_waddr = phys(head, j + IW'(1));
          mem_wdata = rdata;
          if (j == '0) begin
            state_next = S_INS_WR;
          end
        end else begin
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = phys(head, j);
        mem_wdata = '{deadline: ins_deadline, period: ins_period,
                      ident: ins_ident, once: ins_once};
        state_next = ticking ? S_POP_RD : S_RESP;
      end
      S_POP_RD: begin
        state_next = (count == '0) ? S_FLUSH : S_POP_CMP;
      end
      S_POP_CMP: begin
        if (!cres.due) begin
          state_next = S_FLUSH;
        end else if (pop_go) begin
          push       = rep_open && pend_valid;
          state_next = rdata.once ? S_POP_RD : S_INS_START;
        end
      end
      S_FLUSH: begin
        // The held report is the final one of this tick.
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          push_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          push       = 1'b1;
          push_kind  = resp_kind;
          push_id    = resp_id;
          push_last  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tick_count   <= '0;
      head         <= '0;
      count        <= '0;
      ticking      <= 1'b0;
      pend_valid   <= 1'b0;
      nrep         <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (push) begin
        result_valid <= 1'b1;
        kind         <= push_kind;
        fired_id     <= push_id;
        last         <= push_last;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            ticking      <= (cmd == dotq_pkg::CMD_TICK);
            pend_valid   <= 1'b0;
            nrep         <= '0;
            ins_deadline <= dl_sum;
            ins_period   <= interval;
            ins_ident    <= timer_id;
            ins_once     <= one_shot;
            resp_id      <= timer_id;
            if (interval == '0) begin
              resp_kind <= dotq_pkg::KIND_ZERO;
            end else if (count == DEPTH_C) begin
              resp_kind <= dotq_pkg::KIND_FULL;
            end else begin
              resp_kind <= dotq_pkg::KIND_SET;
            end
            if (cmd == dotq_pkg::CMD_TICK) begin
              tick_count <= tick_count + dotq_pkg::TICK_W'(1);
            end
          end
        end
        S_INS_START: begin
          j <= (count == '0) ? '0 : cnt_m1[IW-1:0];
        end
        S_INS_CMP: begin
          if (cres.later) begin
            if (j != '0) begin
              j <= j - IW'(1);
            end
          end else begin
            j <= j + IW'(1);
          end
        end
        S_INS_WR: begin
          count <= count + CW'(1);
        end
        S_POP_CMP: begin
          if (pop_go) begin
            head         <= phys(head, IW'(1));
            count        <= cnt_m1;
            ins_deadline <= dl_sum;
            ins_period   <= rdata.period;
            ins_ident    <= rdata.ident;
            ins_once     <= 1'b0;
            // Beyond the report limit a timer is still re-armed but not shown.
            if (rep_open) begin
              pend_id    <= rdata.ident;
              pend_valid <= 1'b1;
              nrep       <= nrep + dotq_pkg::REP_W'(1);
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid || out_free) begin
            pend_valid <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_tick_advance, clk, rst, item_valid && item_ready && cmd == dotq_pkg::CMD_TICK, tick_count == $past(tick_count) + dotq_pkg::TICK_W'(1), "tick word did not advance the count")
  `ASSERT_IMPLY(a_insert_room, clk, rst, state == S_INS_WR, count < DEPTH_C, "insert into a full table")
  `ASSERT_IMPLY(a_mid_is_fired, clk, rst, result_valid && !last, kind == dotq_pkg::KIND_FIRED, "non-final word that is not an expiry")
  `ASSERT_IMPLY(a_pend_counted, clk, rst, pend_valid, nrep != '0 && nrep <= REP_MAX, "held report without a report count")

endmodule

@@ test/tb_deadline_ordered_timer_queue.sv @@
// Self-checking testbench for the deadline ordered timer queue: directed and random words
// with random idling on both channels, checked against an in-bench timer table predictor.
// Depends on dotq_pkg and deadline_ordered_timer_queue.
`timescale 1ns / 1ps

module tb_deadline_ordered_timer_queue;

  // One result word as the block should report it.
  typedef struct packed {
    logic [dotq_pkg::KIND_W-1:0] code;
    logic [dotq_pkg::ID_W-1:0]   ident;
    logic                        final_word;
  } report_t;

  // Scoreboard: a copy of the timer table plus the queue of reports it predicts.
  class timer_report_board;
    logic [dotq_pkg::TICK_W-1:0]   now_tick;
    logic [dotq_pkg::TICK_W-1:0]   due_at[dotq_pkg::DEPTH_DEF];
    logic [dotq_pkg::PERIOD_W-1:0] reload[dotq_pkg::DEPTH_DEF];
    logic [dotq_pkg::ID_W-1:0]     owner[dotq_pkg::DEPTH_DEF];
    logic                          single[dotq_pkg::DEPTH_DEF];
    int                            used;
    report_t                       awaited_reports[$];
    int                            errors;
    int                            n_ticks, n_armed, n_zero, n_full, n_fired, widest_burst;

    function new();
      now_tick = '0;
      used = 0;
      errors = 0;
      n_ticks = 0;
      n_armed = 0;
      n_zero = 0;
      n_full = 0;
      n_fired = 0;
      widest_burst = 0;
    endfunction

    // Sorted insert by remaining ticks; equal deadlines keep arrival order.
    function void arm_timer(logic [dotq_pkg::ID_W-1:0] id,
                            logic [dotq_pkg::PERIOD_W-1:0] period, logic once);
      int pos;
      pos = used;
      for (int i = 0; i < used; i++) begin
        if ((due_at[i] - now_tick) >
            {{(dotq_pkg::TICK_W-dotq_pkg::PERIOD_W){1'b0}}, period}) begin
          pos = i;
          break;
        end
      end
      for (int i = used; i > pos; i--) begin
        due_at[i] = due_at[i-1];
        reload[i] = reload[i-1];
        owner[i]  = owner[i-1];
        single[i] = single[i-1];
      end
      due_at[pos] = now_tick + {{(dotq_pkg::TICK_W-dotq_pkg::PERIOD_W){1'b0}}, period};
      reload[pos] = period;
      owner[pos]  = id;
      single[pos] = once;
      used++;
    endfunction

    // One tick: pull every timer due now off the front, report it, re-arm periodic ones.
    function void advance_tick();
      logic [dotq_pkg::PERIOD_W-1:0] hit_period[dotq_pkg::DEPTH_DEF];
      logic [dotq_pkg::ID_W-1:0]     hit_id[dotq_pkg::DEPTH_DEF];
      logic                          hit_once[dotq_pkg::DEPTH_DEF];
      int                            n;
      int                            reported;
      report_t                       r;
      n = 0;
      reported = 0;
      now_tick = now_tick + dotq_pkg::TICK_W'(1);
      while (n < used && due_at[n] == now_tick) begin
        hit_period[n] = reload[n];
        hit_id[n]     = owner[n];
        hit_once[n]   = single[n];
        n++;
      end
      for (int i = n; i < used; i++) begin
        due_at[i-n] = due_at[i];
        reload[i-n] = reload[i];
        owner[i-n]  = owner[i];
        single[i-n] = single[i];
      end
      used -= n;
      for (int i = 0; i < n; i++) begin
        if (reported < dotq_pkg::MAX_RESULTS) begin
          r.code = dotq_pkg::KIND_FIRED;
          r.ident = hit_id[i];
          r.final_word = 1'b0;
          awaited_reports.push_back(r);
          reported++;
        end
        if (!hit_once[i] && hit_period[i] != '0 && used < dotq_pkg::DEPTH_DEF)
          arm_timer(hit_id[i], hit_period[i], 1'b0);
      end
      if (reported > 0)
        awaited_reports[awaited_reports.size()-1].final_word = 1'b1;
      n_fired += reported;
      if (reported > widest_burst)
        widest_burst = reported;
    endfunction

    function void note_word(logic c, logic [dotq_pkg::ID_W-1:0] id,
                            logic [dotq_pkg::PERIOD_W-1:0] iv, logic once);
      report_t r;
      if (c == dotq_pkg::CMD_TICK) begin
        n_ticks++;
        advance_tick();
      end else begin
        r.ident = id;
        r.final_word = 1'b1;
        if (iv == '0) begin
          r.code = dotq_pkg::KIND_ZERO;
          n_zero++;
        end else if (used >= dotq_pkg::DEPTH_DEF) begin
          r.code = dotq_pkg::KIND_FULL;
          n_full++;
        end else begin
          arm_timer(id, iv, once);
          r.code = dotq_pkg::KIND_SET;
          n_armed++;
        end
        awaited_reports.push_back(r);
      end
    endfunction

    function void check_report(logic [dotq_pkg::KIND_W-1:0] k, logic [dotq_pkg::ID_W-1:0] id,
                               logic l);
      report_t e;
      if (awaited_reports.size() == 0) begin
        $display("%0t: result word with nothing expected: kind %0d id %02h last %0b",
                 $time, k, id, l);
        errors++;
        return;
      end
      e = awaited_reports.pop_front();
      if (k !== e.code) begin
        $display("%0t: kind expected %0d got %0d", $time, e.code, k);
        errors++;
      end
      if (id !== e.ident) begin
        $display("%0t: fired_id expected %02h got %02h", $time, e.ident, id);
        errors++;
      end
      if (l !== e.final_word) begin
        $display("%0t: last expected %0b got %0b", $time, e.final_word, l);
        errors++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          item_valid = 1'b0;
  logic                          item_ready;
  logic                          cmd = dotq_pkg::CMD_TICK;
  logic [dotq_pkg::ID_W-1:0]     timer_id = '0;
  logic [dotq_pkg::PERIOD_W-1:0] interval = '0;
  logic                          one_shot = 1'b0;
  logic                          result_valid;
  logic                          result_ready = 1'b0;
  logic [dotq_pkg::KIND_W-1:0]   kind;
  logic [dotq_pkg::ID_W-1:0]     fired_id;
  logic                          last;

  // Percent of cycles in which the sender holds off and the receiver stalls.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  timer_report_board board = new();

  deadline_ordered_timer_queue #(.DEPTH(dotq_pkg::DEPTH_DEF)) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .cmd          (cmd),
    .timer_id     (timer_id),
    .interval     (interval),
    .one_shot     (one_shot),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .fired_id     (fired_id),
    .last         (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side. Values read right after the edge are the ones the edge sampled,
  // since the block and this bench both update through nonblocking assignments.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready)
      board.check_report(kind, fired_id, last);
    result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Offer one word and hold it until accepted. The valid is only lowered when
  // an idle gap is taken, so back-to-back words never see a low-high pair in
  // one time step.
  task automatic send_word(input logic c, input logic [dotq_pkg::ID_W-1:0] id,
                           input logic [dotq_pkg::PERIOD_W-1:0] iv, input logic once);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    item_valid <= 1'b1;
    cmd        <= c;
    timer_id   <= id;
    interval   <= iv;
    one_shot   <= once;
    do @(posedge clk); while (!item_ready);
    board.note_word(c, id, iv, once);
  endtask

  task automatic set_timer(input logic [dotq_pkg::ID_W-1:0] id,
                           input logic [dotq_pkg::PERIOD_W-1:0] iv, input logic once);
    send_word(dotq_pkg::CMD_SET, id, iv, once);
  endtask

  // The other fields of a tick word are don't-care, so they carry noise.
  task automatic tick_once();
    logic [dotq_pkg::ID_W-1:0]     id;
    logic [dotq_pkg::PERIOD_W-1:0] iv;
    logic                          once;
    id   = dotq_pkg::ID_W'($urandom_range(0, 255));
    iv   = $urandom;
    once = 1'($urandom_range(0, 1));
    send_word(dotq_pkg::CMD_TICK, id, iv, once);
  endtask

  // Random mix: ticks outnumber sets so one-shot timers drain; periodic and huge
  // intervals stay rare because such timers never leave the table.
  task automatic random_word();
    int                            pick;
    logic [dotq_pkg::ID_W-1:0]     id;
    logic [dotq_pkg::PERIOD_W-1:0] iv;
    logic                          once;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      tick_once();
    end else begin
      pick = $urandom_range(0, 99);
      id   = dotq_pkg::ID_W'($urandom_range(0, 255));
      once = 1'b1;
      iv   = $urandom_range(1, 8);
      if (pick < 8) begin
        iv   = '0;
        once = 1'($urandom_range(0, 1));
      end else if (pick < 13) begin
        iv = $urandom;
      end else if (pick < 25) begin
        once = 1'b0;
        iv   = $urandom_range(1, 6);
      end
      set_timer(id, iv, once);
    end
  endtask

  initial begin
    int phase_send[4];
    int phase_recv[4];
    phase_send = '{0, 76, 0, 30};
    phase_recv = '{0, 0, 76, 30};

    rst <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part, run without idling. A tick on the empty table must stay quiet,
    // and a zero interval is refused even with room left.
    tick_once();
    set_timer(8'hA5, '0, 1'b1);

    // Fill the table: the largest interval, sorted inserts that push entries up,
    // equal deadlines that must keep their arrival order, and one periodic timer.
    set_timer(8'h00, 32'hFFFF_FFFF, 1'b1);
    for (int i = 0; i < 6; i++)
      set_timer(dotq_pkg::ID_W'(8'h30 + i), 32'd3, 1'b1);
    set_timer(8'h11, 32'd1, 1'b1);
    set_timer(8'hFF, 32'd2, 1'b0);
    set_timer(8'h12, 32'd1, 1'b1);
    for (int i = 6; i < 12; i++)
      set_timer(dotq_pkg::ID_W'(8'h30 + i), 32'd3, 1'b1);

    // Table is full now: a good set is refused as full, while a zero interval
    // still reports the zero-interval refusal since that check comes first.
    set_timer(8'h5A, 32'd5, 1'b1);
    set_timer(8'hC3, '0, 1'b0);

    // Drain: the two equal deadlines, the periodic timer, a burst of twelve
    // expiries, then the periodic timer again after its reload.
    repeat (4) tick_once();

    // Random part through the idling phases.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      repeat (22) random_word();
    end

    item_valid <= 1'b0;
    recv_stall_pct = 0;
    while (board.awaited_reports.size() != 0) @(posedge clk);
    // A full re-arm pass can keep the block busy.
    repeat (400) @(posedge clk);

    $display("Covered %0d ticks and %0d set words (%0d armed, %0d zero, %0d table full).",
             board.n_ticks, board.n_armed + board.n_zero + board.n_full,
             board.n_armed, board.n_zero, board.n_full);
    $display("Saw %0d expiries, up to %0d reported on a single tick.",
             board.n_fired, board.widest_burst);
    if (board.errors == 0)
      $display("deadline_ordered_timer_queue: match");
    else
      $display("deadline_ordered_timer_queue: mismatch");
    $finish;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #(5_000_000);
    $display("Run limit reached with %0d result words outstanding.",
             board.awaited_reports.size());
    $display("deadline_ordered_timer_queue: mismatch");
    $finish;
  end

endmodule
